/* design/assert_macros.svh */
// Assertion helpers for the slot table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RIS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define RIS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);
`else
`define RIS_ASSERT(lbl, clk, rstn, prop, msg)
`define RIS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

/* design/ristab_pkg.sv */
`timescale 1ns / 1ps
package ristab_pkg;

    localparam int TABLE_SLOTS_DEF     = 64;
    localparam int INODES_IN_BLOCK_DEF = 64;
    localparam int INODE_BYTES_DEF     = 64;

    localparam int MAX_IDX_W = 8;

    localparam logic [15:0] FIRST_BLOCK_RST = 16'd3;

    localparam logic [1:0] REQ_GET   = 2'd0;
    localparam logic [1:0] REQ_PUT   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_LOADED   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_IGNORED  = 3'd3;
    localparam logic [2:0] ST_RELEASED = 3'd4;
    localparam logic [2:0] ST_HELD     = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           req;
        logic [15:0]          key;
        logic [5:0]           slot;
        logic                 hit;
        logic [MAX_IDX_W-1:0] hit_idx;
        logic                 free;
        logic [MAX_IDX_W-1:0] free_idx;
        logic                 put_hit;
        logic                 put_zero;
        logic [15:0]          put_inode;
    } probe_t;

    typedef struct packed {
        logic                 we;
        logic [MAX_IDX_W-1:0] idx;
        logic [15:0]          inode;
    } commit_t;

endpackage

/* design/ristab_cell.sv */
`timescale 1ns / 1ps
module ristab_cell #(
    parameter int IDX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ristab_pkg::probe_t  probe_in,
    input  ristab_pkg::commit_t commit,
    output ristab_pkg::probe_t  probe_out
);
    import ristab_pkg::*;

    logic [15:0] inode_reg;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    probe_t      probe_reg;
    probe_t      probe_next;
    logic        in_use;
    logic        slot_match;
    logic        commit_match;

    assign in_use       = (count_reg != 16'd0);
    assign slot_match   = (32'(probe_in.slot) == 32'(IDX));
    assign commit_match = commit.we && (commit.idx == MAX_IDX_W'(IDX));

    always_comb begin
        probe_next = probe_in;
        count_next = count_reg;
        if (probe_in.valid) begin
            case (probe_in.req)
                REQ_GET: begin
                    if (!probe_in.hit && in_use && inode_reg == probe_in.key) begin
                        probe_next.hit     = 1'b1;
                        probe_next.hit_idx = MAX_IDX_W'(IDX);
                        if (count_reg != 16'hFFFF) begin
                            count_next = count_reg + 16'd1;
                        end
                    end else if (!probe_in.free && !in_use) begin
                        probe_next.free     = 1'b1;
                        probe_next.free_idx = MAX_IDX_W'(IDX);
                    end
                end
                REQ_PUT: begin
                    if (slot_match && in_use) begin
                        probe_next.put_hit   = 1'b1;
                        probe_next.put_zero  = (count_reg == 16'd1);
                        probe_next.put_inode = inode_reg;
                        count_next           = count_reg - 16'd1;
                    end
                end
                REQ_CLEAR: begin
                    count_next = 16'd0;
                end
                default: begin
                end
            endcase
        end
        if (commit_match) begin
            count_next = 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= 16'd0;
            probe_reg.valid <= 1'b0;
        end else begin
            count_reg       <= count_next;
            probe_reg.valid <= probe_next.valid;
        end
        probe_reg.req       <= probe_next.req;
        probe_reg.key       <= probe_next.key;
        probe_reg.slot      <= probe_next.slot;
        probe_reg.hit       <= probe_next.hit;
        probe_reg.hit_idx   <= probe_next.hit_idx;
        probe_reg.free      <= probe_next.free;
        probe_reg.free_idx  <= probe_next.free_idx;
        probe_reg.put_hit   <= probe_next.put_hit;
        probe_reg.put_zero  <= probe_next.put_zero;
        probe_reg.put_inode <= probe_next.put_inode;
        if (commit_match) begin
            inode_reg <= commit.inode;
        end
    end

    assign probe_out = probe_reg;

endmodule

/* design/refcounted_inode_slot_table_top.sv */
`timescale 1ns / 1ps
// Reference-counted inode slot table. Requests are taken one at a time: a beat
// is accepted only when the block is idle, and its result is loaded into the
// output register once it has passed these steps in order: the lookup token
// walks the row of slot cells one cell per cycle, the outcome is captured, the
// S_QUOT and S_REM states turn the inode number into block and offset, and the
// S_OUT state commits a newly taken slot and loads the output register, waiting
// there while an earlier result is still held. The block then returns to idle
// for the next beat. A finished result may wait in the output register while
// the next request already runs. Count saturates at 0xFFFF; inode numbers of
// free slots are never looked at, so they need no reset.
`include "assert_macros.svh"
module refcounted_inode_slot_table_top #(
    parameter int TABLE_SLOTS     = ristab_pkg::TABLE_SLOTS_DEF,
    parameter int INODES_IN_BLOCK = ristab_pkg::INODES_IN_BLOCK_DEF,
    parameter int INODE_BYTES     = ristab_pkg::INODE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // inode_number [15:0], slot_index [21:16], zero [23:22]
    input  logic [23:0] s_tdata,
    // req_type [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_slot [5:0], disk_action [7:6], disk_block [23:8],
    // byte_offset [35:24], action_inode [51:36], zero [55:52]
    output logic [55:0] m_tdata,
    // status [2:0]
    output logic [2:0]  m_tuser
);
    import ristab_pkg::*;

    localparam int DIV_SHIFT = 16 + $clog2(INODES_IN_BLOCK);
    localparam int DIV_MULT  = ((1 << DIV_SHIFT) + INODES_IN_BLOCK - 1) / INODES_IN_BLOCK;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_QUOT = 5'b00100,
        S_REM  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [15:0] cfg_reg;
    probe_t      inj_reg;
    probe_t      chain [TABLE_SLOTS+1];
    probe_t      tail;
    commit_t     commit;

    logic [2:0]           res_status_reg;
    logic [5:0]           res_slot_reg;
    logic [1:0]           res_action_reg;
    logic [15:0]          dinode_reg;
    logic [MAX_IDX_W-1:0] new_idx_reg;
    logic [15:0]          new_inode_reg;
    logic [15:0]          quot_reg;
    logic [7:0]           rem_reg;

    logic [2:0]  cap_status;
    logic [5:0]  cap_slot;
    logic [1:0]  cap_action;
    logic [15:0] cap_dinode;
    logic [32:0] quot_prod;
    logic [23:0] back_prod;
    logic [19:0] off_prod;
    logic [15:0] blk;
    logic        out_load;

    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    assign chain[0] = inj_reg;
    assign tail     = chain[TABLE_SLOTS];

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        ristab_cell #(
            .IDX(g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .probe_in (chain[g]),
            .commit   (commit),
            .probe_out(chain[g+1])
        );
    end

    assign s_tready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    assign commit.we    = out_load && (res_status_reg == ST_LOADED);
    assign commit.idx   = new_idx_reg;
    assign commit.inode = new_inode_reg;

    always_comb begin
        cap_status = ST_IGNORED;
        cap_slot   = 6'd0;
        cap_action = ACT_NONE;
        cap_dinode = tail.key;
        case (tail.req)
            REQ_GET: begin
                if (tail.hit) begin
                    cap_status = ST_HIT;
                    cap_slot   = 6'(tail.hit_idx);
                end else if (tail.free) begin
                    cap_status = ST_LOADED;
                    cap_slot   = 6'(tail.free_idx);
                    cap_action = ACT_READ;
                end else begin
                    cap_status = ST_FULL;
                end
            end
            REQ_PUT: begin
                cap_slot   = tail.slot;
                cap_dinode = tail.put_inode;
                if (!tail.put_hit) begin
                    cap_status = ST_IGNORED;
                end else if (tail.put_zero) begin
                    cap_status = ST_RELEASED;
                    cap_action = ACT_WRITE;
                end else begin
                    cap_status = ST_HELD;
                end
            end
            REQ_CLEAR: begin
                cap_status = ST_CLEARED;
            end
            default: begin
            end
        endcase
    end

    assign quot_prod = 33'(dinode_reg) * 33'(DIV_MULT);
    assign back_prod = 24'(quot_reg) * 24'(INODES_IN_BLOCK);
    assign off_prod  = 20'(rem_reg) * 20'(INODE_BYTES);
    assign blk       = quot_reg + cfg_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tail.valid) begin
                    state_next = S_QUOT;
                end
            end
            S_QUOT: state_next = S_REM;
            S_REM:  state_next = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cfg_reg       <= FIRST_BLOCK_RST;
            inj_reg.valid <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            inj_reg.valid <= s_tvalid && s_tready;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (s_tvalid && s_tready) begin
            inj_reg.req       <= s_tuser;
            inj_reg.key       <= s_tdata[15:0];
            inj_reg.slot      <= s_tdata[21:16];
            inj_reg.hit       <= 1'b0;
            inj_reg.hit_idx   <= '0;
            inj_reg.free      <= 1'b0;
            inj_reg.free_idx  <= '0;
            inj_reg.put_hit   <= 1'b0;
            inj_reg.put_zero  <= 1'b0;
            inj_reg.put_inode <= 16'd0;
        end
        if (state_reg == S_SCAN && tail.valid) begin
            res_status_reg <= cap_status;
            res_slot_reg   <= cap_slot;
            res_action_reg <= cap_action;
            dinode_reg     <= cap_dinode;
            new_idx_reg    <= tail.free_idx;
            new_inode_reg  <= tail.key;
        end
        if (state_reg == S_QUOT) begin
            quot_reg <= 16'(quot_prod >> DIV_SHIFT);
        end
        if (state_reg == S_REM) begin
            rem_reg <= 8'(dinode_reg - 16'(back_prod));
        end
        if (out_load) begin
            m_tuser_reg <= res_status_reg;
            if (res_action_reg == ACT_NONE) begin
                m_tdata_reg <= {4'd0, 16'd0, 12'd0, 16'd0, res_action_reg, res_slot_reg};
            end else begin
                m_tdata_reg <= {4'd0, dinode_reg, 12'(off_prod), blk, res_action_reg,
                                res_slot_reg};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `RIS_ASSERT(a_idle_no_token, aclk, aresetn, (state_reg == S_IDLE) |-> !tail.valid, "lookup token left the chain while idle")
    `RIS_ASSERT_NEXT(a_accept_scan, aclk, aresetn, s_tvalid && s_tready, state_reg == S_SCAN, "accepted beat did not start a scan")
    `RIS_ASSERT(a_commit_loaded, aclk, aresetn, commit.we |-> (state_reg == S_OUT && res_action_reg == ACT_READ), "slot taken without a disk read")
    `RIS_ASSERT(a_no_action_zero, aclk, aresetn, (m_tvalid && m_tdata[7:6] == ACT_NONE) |-> (m_tdata[51:8] == 44'd0), "disk fields set without a disk action")

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import ristab_pkg::*;

    localparam int         SLOTS       = TABLE_SLOTS_DEF;
    localparam logic [1:0] REQ_BAD     = 2'd3;
    localparam int         ITEM_GOAL   = 800;
    localparam int         HOLD_CYCLES = 600;
    localparam int         CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [1:0]  action;
        logic [15:0] disk_block;
        logic [11:0] offset;
        logic [15:0] inode;
    } slot_reply_t;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] inode;
        logic [5:0]  slot;
        logic        fixed;
        slot_reply_t reply;
    } plan_row_t;

    localparam slot_reply_t NO_REPLY = '0;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;

    logic [15:0] slot_inode [SLOTS];
    logic [15:0] slot_refs  [SLOTS];
    logic [15:0] area_base;
    slot_reply_t replies_due [$];

    int errors      = 0;
    int beats_in    = 0;
    int beats_out   = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit held_off    = 1'b0;
    bit calm        = 1'b0;

    plan_row_t opening_rows [0:20] = '{
        '{REQ_PUT,   16'h0000, 6'd0,  1'b1, '{ST_IGNORED,  6'd0,  ACT_NONE,  16'd0,    12'd0,    16'h0000}},
        '{REQ_BAD,   16'hFFFF, 6'd63, 1'b1, '{ST_IGNORED,  6'd0,  ACT_NONE,  16'd0,    12'd0,    16'h0000}},
        '{REQ_GET,   16'h0000, 6'd0,  1'b1, '{ST_LOADED,   6'd0,  ACT_READ,  16'd3,    12'd0,    16'h0000}},
        '{REQ_GET,   16'hFFFF, 6'd63, 1'b1, '{ST_LOADED,   6'd1,  ACT_READ,  16'd1026, 12'd4032, 16'hFFFF}},
        '{REQ_GET,   16'h0000, 6'd0,  1'b1, '{ST_HIT,      6'd0,  ACT_NONE,  16'd0,    12'd0,    16'h0000}},
        '{REQ_PUT,   16'h0000, 6'd0,  1'b1, '{ST_HELD,     6'd0,  ACT_NONE,  16'd0,    12'd0,    16'h0000}},
        '{REQ_PUT,   16'h0000, 6'd0,  1'b1, '{ST_RELEASED, 6'd0,  ACT_WRITE, 16'd3,    12'd0,    16'h0000}},
        '{REQ_PUT,   16'hFFFF, 6'd63, 1'b1, '{ST_IGNORED,  6'd63, ACT_NONE,  16'd0,    12'd0,    16'h0000}},
        '{REQ_GET,   16'h1234, 6'd5,  1'b0, NO_REPLY},
        '{REQ_GET,   16'h0041, 6'd0,  1'b0, NO_REPLY},
        '{REQ_GET,   16'hFFFF, 6'd0,  1'b1, '{ST_HIT,      6'd1,  ACT_NONE,  16'd0,    12'd0,    16'h0000}},
        '{REQ_PUT,   16'h0000, 6'd1,  1'b1, '{ST_HELD,     6'd1,  ACT_NONE,  16'd0,    12'd0,    16'h0000}},
        '{REQ_PUT,   16'h0000, 6'd1,  1'b1, '{ST_RELEASED, 6'd1,  ACT_WRITE, 16'd1026, 12'd4032, 16'hFFFF}},
        '{REQ_GET,   16'h1234, 6'd0,  1'b0, NO_REPLY},
        '{REQ_GET,   16'h8000, 6'd0,  1'b0, NO_REPLY},
        '{REQ_PUT,   16'h0000, 6'd2,  1'b0, NO_REPLY},
        '{REQ_CLEAR, 16'hABCD, 6'd21, 1'b1, '{ST_CLEARED,  6'd0,  ACT_NONE,  16'd0,    12'd0,    16'h0000}},
        '{REQ_PUT,   16'h0000, 6'd0,  1'b1, '{ST_IGNORED,  6'd0,  ACT_NONE,  16'd0,    12'd0,    16'h0000}},
        '{REQ_GET,   16'h1234, 6'd0,  1'b1, '{ST_LOADED,   6'd0,  ACT_READ,  16'd75,   12'd3328, 16'h1234}},
        '{REQ_BAD,   16'h5A5A, 6'd42, 1'b1, '{ST_IGNORED,  6'd0,  ACT_NONE,  16'd0,    12'd0,    16'h0000}},
        '{REQ_CLEAR, 16'h0000, 6'd0,  1'b1, '{ST_CLEARED,  6'd0,  ACT_NONE,  16'd0,    12'd0,    16'h0000}}
    };

    refcounted_inode_slot_table_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic slot_reply_t disk_request(slot_reply_t r, logic [1:0] act,
                                                 logic [15:0] ino);
        logic [31:0] off;
        off          = 32'(ino % INODES_IN_BLOCK_DEF) * INODE_BYTES_DEF;
        r.action     = act;
        r.disk_block = 16'(ino / INODES_IN_BLOCK_DEF) + area_base;
        r.offset     = off[11:0];
        r.inode      = ino;
        return r;
    endfunction

    function automatic slot_reply_t serve_request(logic [1:0] req, logic [15:0] ino,
                                                  logic [5:0] sl);
        slot_reply_t r;
        int          hit_at;
        int          free_at;
        r       = '0;
        hit_at  = -1;
        free_at = -1;
        case (req)
            REQ_GET: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (hit_at < 0 && slot_refs[i] != 0 && slot_inode[i] == ino) begin
                        hit_at = i;
                    end
                    if (free_at < 0 && slot_refs[i] == 0) begin
                        free_at = i;
                    end
                end
                if (hit_at >= 0) begin
                    if (slot_refs[hit_at] != 16'hFFFF) begin
                        slot_refs[hit_at]++;
                    end
                    r.status = ST_HIT;
                    r.slot   = 6'(hit_at);
                end else if (free_at < 0) begin
                    r.status = ST_FULL;
                end else begin
                    slot_refs[free_at]  = 16'd1;
                    slot_inode[free_at] = ino;
                    r.status            = ST_LOADED;
                    r.slot              = 6'(free_at);
                    r                   = disk_request(r, ACT_READ, ino);
                end
            end
            REQ_PUT: begin
                r.slot = sl;
                if (int'(sl) >= SLOTS || slot_refs[sl] == 0) begin
                    r.status = ST_IGNORED;
                end else begin
                    slot_refs[sl]--;
                    if (slot_refs[sl] == 0) begin
                        r.status = ST_RELEASED;
                        r        = disk_request(r, ACT_WRITE, slot_inode[sl]);
                    end else begin
                        r.status = ST_HELD;
                    end
                end
            end
            REQ_CLEAR: begin
                foreach (slot_refs[i]) slot_refs[i] = '0;
                r.status = ST_CLEARED;
            end
            default: begin
                r.status = ST_IGNORED;
            end
        endcase
        return r;
    endfunction

    function automatic int free_slots();
        int n;
        n = 0;
        foreach (slot_refs[i]) if (slot_refs[i] == 0) n++;
        return n;
    endfunction

    function automatic logic [5:0] busy_slot();
        int held [$];
        foreach (slot_refs[i]) if (slot_refs[i] != 0) held.push_back(i);
        if (held.size() == 0) return 6'($urandom);
        return 6'(held[$urandom_range(held.size() - 1)]);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    task automatic send_request(logic [1:0] req, logic [15:0] ino, logic [5:0] sl,
                                bit fixed = 1'b0, slot_reply_t fixed_reply = '0);
        slot_reply_t r;
        while (!calm && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            repeat (($urandom_range(9) == 0) ? $urandom_range(80, 1) : 1) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, sl, ino};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = serve_request(req, ino, sl);
        replies_due.push_back(fixed ? fixed_reply : r);
        beats_in++;
        calm = (beats_in >= 400 && beats_in < 520);
    endtask

    task automatic settle(int extra);
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_area_base(logic [15:0] value);
        settle(8);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        area_base = value;
    endtask

    task automatic run_episode();
        logic [15:0] pool [8];
        int          kind;
        kind = $urandom_range(9);
        foreach (pool[i]) pool[i] = 16'($urandom);
        if (kind <= 5) begin
            repeat (20) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: send_request(REQ_GET, pool[$urandom_range(7)], 6'($urandom));
                    5, 6, 7:       send_request(REQ_PUT, 16'($urandom), busy_slot());
                    8:             send_request(REQ_PUT, 16'($urandom), 6'($urandom));
                    default:       send_request(2'($urandom), 16'($urandom), 6'($urandom));
                endcase
            end
        end else if (kind <= 7) begin
            // fill the table, run into the full case, then drain part of it
            while (free_slots() != 0) send_request(REQ_GET, 16'($urandom), 6'($urandom));
            repeat (2) send_request(REQ_GET, 16'($urandom), 6'($urandom));
            send_request(REQ_GET, slot_inode[$urandom_range(SLOTS - 1)], 6'($urandom));
            repeat (40) send_request(REQ_PUT, 16'($urandom), busy_slot());
        end else if (kind == 8) begin
            send_request(REQ_CLEAR, 16'($urandom), 6'($urandom));
            repeat (5) send_request(REQ_GET, pool[$urandom_range(3)], 6'($urandom));
        end else begin
            repeat (10) send_request(2'($urandom), 16'($urandom), 6'($urandom));
        end
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("refcounted_inode_slot_table_top: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        slot_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (replies_due.size() == 0) begin
                $error("result beat with nothing pending: status %0d", m_tuser);
                errors++;
            end else begin
                want = replies_due.pop_front();
                check_field("status",       16'(want.status),     16'(m_tuser));
                check_field("result_slot",  16'(want.slot),       16'(m_tdata[5:0]));
                check_field("disk_action",  16'(want.action),     16'(m_tdata[7:6]));
                check_field("disk_block",   want.disk_block,      m_tdata[23:8]);
                check_field("byte_offset",  16'(want.offset),     16'(m_tdata[35:24]));
                check_field("action_inode", want.inode,           m_tdata[51:36]);
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!held_off && beats_out >= 120) begin
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 19);
        end
    end

    initial begin
        logic [15:0] bases [4];
        foreach (slot_refs[i]) slot_refs[i] = '0;
        area_base = FIRST_BLOCK_RST;
        bases     = '{16'h0000, 16'hFFFF, 16'($urandom), 16'h8000};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (opening_rows[i]) begin
            send_request(opening_rows[i].req, opening_rows[i].inode, opening_rows[i].slot,
                         opening_rows[i].fixed, opening_rows[i].reply);
        end
        foreach (bases[p]) begin
            set_area_base(bases[p]);
            while (beats_in < 25 + (p + 1) * ITEM_GOAL / 4) run_episode();
        end
        settle(SLOTS + 40);
        if (errors == 0) begin
            $display("refcounted_inode_slot_table_top: match");
        end else begin
            $display("refcounted_inode_slot_table_top: mismatch");
        end
        $finish;
    end

endmodule
